### rtl/tnq_pkg.sv
package tnq_pkg;

    localparam logic CMD_SCHEDULE  = 1'b0;
    localparam logic CMD_POLL      = 1'b1;
    localparam logic KIND_NOTE_ON  = 1'b0;
    localparam logic KIND_NOTE_OFF = 1'b1;

    // stored event: {time, velocity, note, channel, kind}
    localparam int EV_KIND_LSB   = 0;
    localparam int EV_CHAN_LSB   = 1;
    localparam int EV_NOTE_LSB   = 5;
    localparam int EV_VEL_LSB    = 12;
    localparam int EV_META_BITS  = 19;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SHIFT,
        S_PLACE,
        S_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        command;
        logic        event_kind;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] when;
        logic [31:0] current_time;
    } t_request;

    typedef struct packed {
        logic        due_valid;
        logic        out_kind;
        logic [3:0]  out_channel;
        logic [6:0]  out_note;
        logic [6:0]  out_velocity;
        logic [31:0] out_time;
        logic [6:0]  pending_count;
        logic        dropped;
        logic [31:0] sent_total;
        logic [31:0] scheduled_total;
    } t_result;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_seq_status;

endpackage

### rtl/timed_note_event_queue.sv
// Timed note event queue: note-on/note-off events kept in send-time order.
// Request channel: i_valid / o_stall with i_command and the event fields.
//   A schedule request inserts an event behind all queued events of equal or
//   earlier time; when QUEUE_DEPTH events wait, it is dropped and flagged.
//   A poll request returns the earliest event if its time is at or before
//   i_current_time, removing it from the queue.
// Result channel: o_valid / i_stall, one result per request, carrying the
//   pending count and the running sent and scheduled totals.
// Events sit in one RAM used as a ring; the head pointer makes removal a
// single read. An insert steps back from the tail, one entry per cycle,
// moving each later event up one slot through the RAM's read and write port.
// Poll: S_START reads the head and S_POP takes it if due; an empty queue skips S_POP.
// Schedule: an empty or full queue finishes in S_START; otherwise S_SHIFT moves each
// queued event with a later time up one slot, then the new event is written.
// One request is in flight at a time; o_stall is high while it is worked on.
// The next request is taken the cycle after a result loads.
// A finished result sits in the output register, so a new request is taken
// while the receiver stalls; the next result waits until that slot frees.
// Reset empties the queue and clears both totals; RAM contents are not
// cleared since only occupied slots are ever read.
module timed_note_event_queue import tnq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic        i_event_kind,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_note,
    input  logic [6:0]  i_velocity,
    input  logic [31:0] i_when,
    input  logic [31:0] i_current_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_due_valid,
    output logic        o_out_kind,
    output logic [3:0]  o_out_channel,
    output logic [6:0]  o_out_note,
    output logic [6:0]  o_out_velocity,
    output logic [31:0] o_out_time,
    output logic [6:0]  o_pending_count,
    output logic        o_dropped,
    output logic [31:0] o_sent_total,
    output logic [31:0] o_scheduled_total
);

    t_request    req;
    t_seq_status seq_status;
    t_result     seq_res;
    logic        start;
    logic        take;
    logic        r_o_valid;
    t_result     r_res;

    assign req.command      = i_command;
    assign req.event_kind   = i_event_kind;
    assign req.channel      = i_channel;
    assign req.note         = i_note;
    assign req.velocity     = i_velocity;
    assign req.when         = i_when;
    assign req.current_time = i_current_time;

    assign o_stall = seq_status.busy;
    assign start   = i_valid & ~seq_status.busy;
    assign take    = seq_status.res_valid & (~r_o_valid | ~i_stall);

    tnq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (req),
        .i_take   (take),
        .o_status (seq_status),
        .o_res    (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (take) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= seq_res;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_due_valid       = r_res.due_valid;
    assign o_out_kind        = r_res.out_kind;
    assign o_out_channel     = r_res.out_channel;
    assign o_out_note        = r_res.out_note;
    assign o_out_velocity    = r_res.out_velocity;
    assign o_out_time        = r_res.out_time;
    assign o_pending_count   = r_res.pending_count;
    assign o_dropped         = r_res.dropped;
    assign o_sent_total      = r_res.sent_total;
    assign o_scheduled_total = r_res.scheduled_total;

endmodule

### rtl/tnq_ram.sv
module tnq_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tnq_seq.sv
module tnq_seq import tnq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_request    i_req,
    input  logic        i_take,
    output t_seq_status o_status,
    output t_result     o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TIME_BITS + EV_META_BITS;
    localparam logic [CW:0]   DEPTH_W   = (CW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? LAST_SLOT : p - AW'(1);
    endfunction

    t_state          r_state, n_state;
    t_request        r_req;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_fill, n_fill;
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [31:0]     r_sent, n_sent;
    logic [31:0]     r_sched, n_sched;
    logic            r_due, n_due;
    logic            r_drop, n_drop;
    logic [EW-1:0]   r_got, n_got;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;

    logic [EW-1:0]        new_ev;
    logic [TIME_BITS-1:0] new_time;
    logic [TIME_BITS-1:0] rd_time;
    logic [TIME_BITS-1:0] now;
    logic [CW:0]          tail_sum;
    logic [AW-1:0]        tail;

    tnq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign new_time = TIME_BITS'(r_req.when);
    assign now      = TIME_BITS'(r_req.current_time);
    assign new_ev   = {new_time,
                       (r_req.event_kind == KIND_NOTE_OFF) ? 7'd0 : r_req.velocity,
                       r_req.note, r_req.channel, r_req.event_kind};
    assign rd_time  = ram_rdata[EW-1:EV_META_BITS];

    // slot just past the last (latest-time) entry
    assign tail_sum = (CW+1)'(r_head) + (CW+1)'(r_fill);
    assign tail     = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_sent  <= '0;
            r_sched <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_sent  <= n_sent;
            r_sched <= n_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req <= i_req;
        end
        r_wr   <= n_wr;
        r_rd   <= n_rd;
        r_cnt  <= n_cnt;
        r_due  <= n_due;
        r_drop <= n_drop;
        r_got  <= n_got;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_fill    = r_fill;
        n_wr      = r_wr;
        n_rd      = r_rd;
        n_cnt     = r_cnt;
        n_sent    = r_sent;
        n_sched   = r_sched;
        n_due     = r_due;
        n_drop    = r_drop;
        n_got     = r_got;
        ram_we    = 1'b0;
        ram_waddr = r_wr;
        ram_wdata = new_ev;
        ram_raddr = r_rd;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_due  = 1'b0;
                n_drop = 1'b0;
                n_got  = '0;
                if (r_req.command == CMD_SCHEDULE) begin
                    if (r_fill == DEPTH_C) begin
                        n_drop  = 1'b1;
                        n_state = S_DONE;
                    end else if (r_fill == '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = tail;
                        n_fill    = r_fill + CW'(1);
                        n_sched   = r_sched + 32'd1;
                        n_state   = S_DONE;
                    end else begin
                        // walk back from the tail, moving later events up one slot
                        ram_raddr = ptr_dec(tail);
                        n_rd      = ptr_dec(tail);
                        n_wr      = tail;
                        n_cnt     = r_fill;
                        n_state   = S_SHIFT;
                    end
                end else begin
                    if (r_fill == '0) begin
                        n_state = S_DONE;
                    end else begin
                        ram_raddr = r_head;
                        n_state   = S_POP;
                    end
                end
            end
            S_SHIFT: begin
                if (rd_time > new_time) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr;
                    ram_wdata = ram_rdata;
                    n_wr      = r_rd;
                    n_cnt     = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        ram_raddr = ptr_dec(r_rd);
                        n_rd      = ptr_dec(r_rd);
                    end
                end else begin
                    // equal times stop here, so the new event lands behind them
                    ram_we    = 1'b1;
                    ram_waddr = r_wr;
                    n_fill    = r_fill + CW'(1);
                    n_sched   = r_sched + 32'd1;
                    n_state   = S_DONE;
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_wr;
                n_fill    = r_fill + CW'(1);
                n_sched   = r_sched + 32'd1;
                n_state   = S_DONE;
            end
            S_POP: begin
                if (rd_time <= now) begin
                    n_got  = ram_rdata;
                    n_due  = 1'b1;
                    n_head = ptr_inc(r_head);
                    n_fill = r_fill - CW'(1);
                    n_sent = r_sent + 32'd1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_status.busy      = (r_state != S_IDLE);
    assign o_status.res_valid = (r_state == S_DONE);

    assign o_res.due_valid       = r_due;
    assign o_res.out_kind        = r_got[EV_KIND_LSB];
    assign o_res.out_channel     = r_got[EV_CHAN_LSB +: 4];
    assign o_res.out_note        = r_got[EV_NOTE_LSB +: 7];
    assign o_res.out_velocity    = r_got[EV_VEL_LSB +: 7];
    assign o_res.out_time        = 32'(r_got[EW-1:EV_META_BITS]);
    assign o_res.pending_count   = 7'(r_fill);
    assign o_res.dropped         = r_drop;
    assign o_res.sent_total      = r_sent;
    assign o_res.scheduled_total = r_sched;

endmodule

### rtl/tnq_checker.sv
module tnq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_command,
    input logic        i_event_kind,
    input logic [3:0]  i_channel,
    input logic [6:0]  i_note,
    input logic [6:0]  i_velocity,
    input logic [31:0] i_when,
    input logic [31:0] i_current_time,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_due_valid,
    input logic        o_out_kind,
    input logic [3:0]  o_out_channel,
    input logic [6:0]  o_out_note,
    input logic [6:0]  o_out_velocity,
    input logic [31:0] o_out_time,
    input logic [6:0]  o_pending_count,
    input logic        o_dropped,
    input logic [31:0] o_sent_total,
    input logic [31:0] o_scheduled_total
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sent_total)
            && $stable(o_scheduled_total) && $stable(o_pending_count))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // one request in flight: an accepted request keeps the input stalled
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_due_valid |-> o_out_time == 32'd0 && o_out_note == 7'd0
            && o_out_velocity == 7'd0 && o_out_channel == 4'd0 && !o_out_kind)
        else $error("event fields set without a due event");

    a_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dropped |-> !o_due_valid)
        else $error("dropped and due in one result");

endmodule

bind timed_note_event_queue tnq_checker u_tnq_checker (.*);

### sim/timed_note_event_queue_checker.sv
module timed_note_event_queue_checker import tnq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic        i_command,
    input  logic        i_event_kind,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_note,
    input  logic [6:0]  i_velocity,
    input  logic [31:0] i_when,
    input  logic [31:0] i_current_time,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic        i_due_valid,
    input  logic        i_out_kind,
    input  logic [3:0]  i_out_channel,
    input  logic [6:0]  i_out_note,
    input  logic [6:0]  i_out_velocity,
    input  logic [31:0] i_out_time,
    input  logic [6:0]  i_pending_count,
    input  logic        i_dropped,
    input  logic [31:0] i_sent_total,
    input  logic [31:0] i_scheduled_total,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_due_count,
    output int          o_drop_count
);

    typedef struct packed {
        logic        kind;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] fire_at;
    } t_note_event;

    t_note_event timeline[$];
    t_result     expected_results[$];
    logic [31:0] sent_count;
    logic [31:0] sched_count;
    int          fail_count = 0;
    int          due_count = 0;
    int          drop_count = 0;
    int          open_results = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = open_results;
    assign o_due_count   = due_count;
    assign o_drop_count  = drop_count;

    // Apply one request to the modeled queue and return the result it yields.
    function automatic t_result apply_request(input t_request req);
        t_result     res;
        t_note_event ev;
        int          pos;
        res = '0;
        if (req.command == CMD_SCHEDULE) begin
            if (timeline.size() >= QUEUE_DEPTH) begin
                res.dropped = 1'b1;
            end else begin
                ev.kind     = req.event_kind;
                ev.channel  = req.channel;
                ev.note     = req.note;
                ev.velocity = (req.event_kind == KIND_NOTE_OFF) ? 7'd0 : req.velocity;
                ev.fire_at  = req.when;
                // ties go behind: first strictly later entry
                pos = timeline.size();
                for (int k = 0; k < timeline.size(); k++) begin
                    if (pos == timeline.size() && timeline[k].fire_at > ev.fire_at)
                        pos = k;
                end
                timeline.insert(pos, ev);
                sched_count++;
            end
        end else begin
            if (timeline.size() > 0 && timeline[0].fire_at <= req.current_time) begin
                ev = timeline.pop_front();
                res.due_valid    = 1'b1;
                res.out_kind     = ev.kind;
                res.out_channel  = ev.channel;
                res.out_note     = ev.note;
                res.out_velocity = ev.velocity;
                res.out_time     = ev.fire_at;
                sent_count++;
            end
        end
        res.pending_count   = 7'(timeline.size());
        res.sent_total      = sent_count;
        res.scheduled_total = sched_count;
        return res;
    endfunction

    function automatic string diff_fields(input t_result want, input t_result got);
        string s;
        s = "";
        if (got.due_valid !== want.due_valid)             s = {s, " due_valid"};
        if (got.out_kind !== want.out_kind)               s = {s, " out_kind"};
        if (got.out_channel !== want.out_channel)         s = {s, " out_channel"};
        if (got.out_note !== want.out_note)               s = {s, " out_note"};
        if (got.out_velocity !== want.out_velocity)       s = {s, " out_velocity"};
        if (got.out_time !== want.out_time)               s = {s, " out_time"};
        if (got.pending_count !== want.pending_count)     s = {s, " pending_count"};
        if (got.dropped !== want.dropped)                 s = {s, " dropped"};
        if (got.sent_total !== want.sent_total)           s = {s, " sent_total"};
        if (got.scheduled_total !== want.scheduled_total) s = {s, " scheduled_total"};
        return s;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf({"due=%b kind=%b ch=%0d note=%0d vel=%0d t=%h",
                          " pend=%0d drop=%b sent=%0d sched=%0d"},
                         r.due_valid, r.out_kind, r.out_channel, r.out_note, r.out_velocity,
                         r.out_time, r.pending_count, r.dropped, r.sent_total,
                         r.scheduled_total);
    endfunction

    always @(posedge i_clk) begin : watch
        t_request req;
        t_result  got;
        t_result  want;
        string    diffs;
        if (!i_rst_n) begin
            timeline.delete();
            expected_results.delete();
            open_results = 0;
            sent_count   = '0;
            sched_count  = '0;
        end else begin
            if (i_req_valid && !i_req_stall) begin
                req.command      = i_command;
                req.event_kind   = i_event_kind;
                req.channel      = i_channel;
                req.note         = i_note;
                req.velocity     = i_velocity;
                req.when         = i_when;
                req.current_time = i_current_time;
                expected_results.insert(expected_results.size(), apply_request(req));
                open_results++;
            end
            if (i_res_valid && !i_res_stall) begin
                got.due_valid       = i_due_valid;
                got.out_kind        = i_out_kind;
                got.out_channel     = i_out_channel;
                got.out_note        = i_out_note;
                got.out_velocity    = i_out_velocity;
                got.out_time        = i_out_time;
                got.pending_count   = i_pending_count;
                got.dropped         = i_dropped;
                got.sent_total      = i_sent_total;
                got.scheduled_total = i_scheduled_total;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: result with no request pending: %s", show(got));
                end else begin
                    want = expected_results.pop_front();
                    open_results--;
                    if (want.due_valid) due_count++;
                    if (want.dropped) drop_count++;
                    diffs = diff_fields(want, got);
                    if (diffs != "") begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch at %0t in%s", $realtime, diffs);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end
        end
    end

endmodule

### sim/timed_note_event_queue_tb.sv
module timed_note_event_queue_tb import tnq_pkg::*; ();

    localparam int QUEUE_DEPTH = 64;
    localparam int ITEM_TARGET = 1650;
    localparam int CALM_TAIL   = 200;
    localparam int CYCLE_LIMIT = 900_000;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = CMD_SCHEDULE;
    logic        i_event_kind = KIND_NOTE_ON;
    logic [3:0]  i_channel = '0;
    logic [6:0]  i_note = '0;
    logic [6:0]  i_velocity = '0;
    logic [31:0] i_when = '0;
    logic [31:0] i_current_time = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_due_valid;
    logic        o_out_kind;
    logic [3:0]  o_out_channel;
    logic [6:0]  o_out_note;
    logic [6:0]  o_out_velocity;
    logic [31:0] o_out_time;
    logic [6:0]  o_pending_count;
    logic        o_dropped;
    logic [31:0] o_sent_total;
    logic [31:0] o_scheduled_total;

    int          fail_count;
    int          outstanding;
    int          due_count;
    int          drop_count;

    int          req_count = 0;
    int          sched_sent = 0;
    int          poll_sent = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;
    int          gap_pct = 0;
    logic [31:0] tick_now;

    timed_note_event_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TIME_BITS  (32)
    ) dut (.*);

    timed_note_event_queue_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_command        (i_command),
        .i_event_kind     (i_event_kind),
        .i_channel        (i_channel),
        .i_note           (i_note),
        .i_velocity       (i_velocity),
        .i_when           (i_when),
        .i_current_time   (i_current_time),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_due_valid      (o_due_valid),
        .i_out_kind       (o_out_kind),
        .i_out_channel    (o_out_channel),
        .i_out_note       (o_out_note),
        .i_out_velocity   (o_out_velocity),
        .i_out_time       (o_out_time),
        .i_pending_count  (o_pending_count),
        .i_dropped        (o_dropped),
        .i_sent_total     (o_sent_total),
        .i_scheduled_total(o_scheduled_total),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_due_count      (due_count),
        .o_drop_count     (drop_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[timed_note_event_queue] ERROR");
        $finish;
    end

    // result-side backpressure: stall bursts of 1..6 between runs of varying length
    int stall_left = 0;
    int run_left = 0;
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (run_left > 0) begin
            i_stall <= 1'b0;
            run_left--;
        end else begin
            run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            stall_left = $urandom_range(1, 6) - 1;
            i_stall <= 1'b1;
        end
    end

    task automatic send_request(input logic cmd, input logic kind, input logic [3:0] chan,
                                input logic [6:0] note, input logic [6:0] vel,
                                input logic [31:0] send_at, input logic [31:0] now);
        if (idle_on && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_command      <= cmd;
        i_event_kind   <= kind;
        i_channel      <= chan;
        i_note         <= note;
        i_velocity     <= vel;
        i_when         <= send_at;
        i_current_time <= now;
        i_valid        <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        req_count++;
        if (cmd == CMD_SCHEDULE) sched_sent++;
        else poll_sent++;
    endtask

    // unused fields carry random noise
    task automatic send_schedule(input logic kind, input logic [3:0] chan,
                                 input logic [6:0] note, input logic [6:0] vel,
                                 input logic [31:0] send_at);
        send_request(CMD_SCHEDULE, kind, chan, note, vel, send_at, $urandom);
    endtask

    task automatic send_poll(input logic [31:0] now);
        send_request(CMD_POLL, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                     7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), $urandom, now);
    endtask

    task automatic random_schedule(input logic [31:0] send_at);
        send_schedule(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                      7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), send_at);
    endtask

    task automatic wait_queue_settled();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        @(posedge i_clk);
    endtask

    initial begin
        int n;
        int sel;
        int r;
        tick_now = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty poll, extremes, equal-time ordering, unsigned compare
        gap_pct = 0;
        send_poll(32'hFFFF_FFFF);
        send_schedule(KIND_NOTE_ON, 4'd15, 7'd127, 7'd127, 32'd100);
        send_schedule(KIND_NOTE_OFF, 4'd0, 7'd0, 7'd127, 32'd100);
        send_schedule(KIND_NOTE_ON, 4'd5, 7'd60, 7'd0, 32'hFFFF_FFFF);
        send_schedule(KIND_NOTE_ON, 4'd0, 7'd0, 7'd1, 32'd0);
        send_schedule(KIND_NOTE_OFF, 4'd9, 7'd64, 7'd33, 32'd50);
        send_schedule(KIND_NOTE_ON, 4'd3, 7'd72, 7'd100, 32'd100);
        send_poll(32'd0);
        send_poll(32'd49);
        send_poll(32'd50);
        send_poll(32'd100);
        send_poll(32'd100);
        send_poll(32'd100);
        send_poll(32'd100);
        send_poll(32'hFFFF_FFFE);
        send_poll(32'hFFFF_FFFF);
        send_poll(32'hFFFF_FFFF);
        send_schedule(KIND_NOTE_OFF, 4'd15, 7'd127, 7'd0, 32'h8000_0000);
        send_poll(32'h7FFF_FFFF);
        send_poll(32'h8000_0000);
        wait_queue_settled();

        sel = 5;  // open with a fill so the full-queue drop is reached early
        while (req_count < ITEM_TARGET) begin
            if (req_count >= ITEM_TARGET - CALM_TAIL && idle_on) begin
                wait_queue_settled();
                idle_on = 1'b0;
            end
            r = $urandom_range(0, 2);
            gap_pct = (r == 0) ? 0 : (r == 1) ? 15 : 45;
            case (sel)
                0, 1, 2, 3, 4: begin
                    n = $urandom_range(20, 60);
                    repeat (n) begin
                        r = $urandom_range(0, 99);
                        if (r < 5) begin
                            random_schedule(tick_now);
                        end else if (r < 10) begin
                            random_schedule(tick_now - $urandom_range(1, 20));
                        end else if (r < 55) begin
                            random_schedule(tick_now + $urandom_range(0, 300));
                        end else begin
                            tick_now = tick_now + $urandom_range(0, 40);
                            send_poll(tick_now);
                        end
                    end
                end
                5, 6: begin
                    // many ties in a narrow window, runs past full
                    n = $urandom_range(66, 72);
                    repeat (n) random_schedule(tick_now + $urandom_range(0, 15));
                end
                7: begin
                    n = $urandom_range(10, 70);
                    repeat (n) begin
                        if ($urandom_range(0, 9) == 0) begin
                            send_poll(32'hFFFF_FFFF);
                        end else begin
                            tick_now = tick_now + $urandom_range(0, 60);
                            send_poll(tick_now);
                        end
                    end
                end
                default: begin
                    n = $urandom_range(10, 30);
                    repeat (n) begin
                        send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                                     7'($urandom_range(0, 127)), $urandom, $urandom);
                    end
                end
            endcase
            if ($urandom_range(0, 5) == 0) wait_queue_settled();
            sel = $urandom_range(0, 8);
        end

        wait_queue_settled();
        repeat (QUEUE_DEPTH + 8) @(posedge i_clk);
        @(negedge i_clk);
        $display("Ran %0d requests: %0d schedules, %0d polls.", req_count, sched_sent,
                 poll_sent);
        $display("Due events returned: %0d; schedules dropped on a full queue: %0d.",
                 due_count, drop_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[timed_note_event_queue] OK");
        end else begin
            $display("[timed_note_event_queue] ERROR");
        end
        $finish;
    end

endmodule
